// ----- hdl/sfcs_pkg.sv -----
package sfcs_pkg;

	// fixed field widths
	localparam int OPCODE_W = 3;
	localparam int ADDR_W   = 24;
	localparam int BYTE_W   = 8;

	localparam int ADDRESS_BITS_DEF = 24;

	localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_WRSR  = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;

	localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INIT        = 3'd0,
		OP_START_WRITE = 3'd1,
		OP_WRITE_BYTE  = 3'd2,
		OP_START_READ  = 3'd3,
		OP_READ_BYTE   = 3'd4,
		OP_END         = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLK,
		ST_DESEL
	} state_t;

endpackage

// ----- hdl/sfcs_req_if.sv -----
interface sfcs_req_if;
	logic                             valid;
	logic                             ready;
	logic [sfcs_pkg::OPCODE_W-1:0]    opcode;
	logic [sfcs_pkg::ADDR_W-1:0]      address;
	logic [sfcs_pkg::BYTE_W-1:0]      write_byte;
	logic [sfcs_pkg::BYTE_W-1:0]      miso_bits;

	modport source (output valid, opcode, address, write_byte, miso_bits, input ready);
	modport sink   (input valid, opcode, address, write_byte, miso_bits, output ready);
endinterface

// ----- hdl/sfcs_rsp_if.sv -----
interface sfcs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          cs_n;
	logic                          clock_pulse;
	logic                          mosi;
	logic [sfcs_pkg::BYTE_W-1:0]   read_byte;
	logic                          read_valid;
	logic                          last;

	modport source (output valid, cs_n, clock_pulse, mosi, read_byte, read_valid, last,
		input ready);
	modport sink   (input valid, cs_n, clock_pulse, mosi, read_byte, read_valid, last,
		output ready);
endinterface

// ----- hdl/sfcs_cfg_if.sv -----
interface sfcs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sfcs_pkg::BYTE_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/spi_fram_command_sequencer.sv -----
// SPI mode-0 sequencer for a serial FRAM. Each request on req yields a train of
// result items on rsp, one per serial clock pulse or chip-select change, MSB
// first, with last set on the final item of the request. Init sends WREN, WRSR
// and the status byte in one frame and deselects (25 items). Start
// write sends WREN, deselects, then opens a frame with WRITE and the address
// (17 + ADDRESS_BITS items, 41 at the default). Start read sends READ and the
// address (8 + ADDRESS_BITS items). Write byte and read byte take 8 items each;
// read byte returns the sampled miso_bits on its last item. End deselects in
// one item. Requests that make no sense in the current select state are
// taken and dropped. Throughput is one result item per clock cycle while rsp
// does not stall, set by the single frame shift register that moves one bit
// per such cycle; a request is taken only while no request is in flight.
// The status word is written through cfg and is always ready.
module spi_fram_command_sequencer #(
	parameter int ADDRESS_BITS = sfcs_pkg::ADDRESS_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sfcs_req_if.sink      req,
	sfcs_rsp_if.source    rsp,
	sfcs_cfg_if.sink      cfg
);

	// frame shift register holds up to two bytes plus the address
	localparam int SH_W   = 2 * sfcs_pkg::BYTE_W + ADDRESS_BITS;
	localparam int FRAME2 = sfcs_pkg::BYTE_W + ADDRESS_BITS;
	localparam int CNT_W  = $clog2(FRAME2 + 1);
	localparam int BW     = sfcs_pkg::BYTE_W;

	sfcs_pkg::state_t state_q, state_d;

	logic [BW-1:0]    status_q;
	logic             sel_q;        // memory selected
	logic [SH_W-1:0]  sh_q;         // outgoing bits, MSB first
	logic [BW-2:0]    acc_q;        // read assembly
	logic [CNT_W-1:0] cnt_q;        // clocks left in current segment
	logic             rd_q;         // segment is a read byte
	logic             desel_q;      // deselect follows this segment
	logic             reopen_q;     // another frame follows that deselect

	// output register
	logic             out_valid_q;
	logic             cs_n_q;
	logic             clk_pulse_q;
	logic             mosi_q;
	logic [BW-1:0]    rb_q;
	logic             rv_q;
	logic             last_q;

	logic             accept;
	logic             emit;
	logic             go_clk;
	logic             go_desel;
	logic             seg_done;
	logic             final_clk;

	logic [SH_W-1:0]  sh_ld;
	logic [CNT_W-1:0] cnt_ld;
	logic             rd_ld;
	logic             desel_ld;
	logic             reopen_ld;

	// address zero-extended or cut to ADDRESS_BITS
	logic [sfcs_pkg::ADDR_W+ADDRESS_BITS-1:0] addr_wide;
	logic [ADDRESS_BITS-1:0]                  addr_ext;

	assign addr_wide = {{ADDRESS_BITS{1'b0}}, req.address};
	assign addr_ext  = addr_wide[ADDRESS_BITS-1:0];

	assign req.ready = (state_q == sfcs_pkg::ST_IDLE);
	assign accept    = req.valid & req.ready;
	assign emit      = ~out_valid_q | rsp.ready;
	assign cfg.ready = 1'b1;

	assign seg_done  = (cnt_q == CNT_W'(1));
	assign final_clk = seg_done & ~desel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and segment load values
	always_comb begin
		state_d   = state_q;
		go_clk    = 1'b0;
		go_desel  = 1'b0;
		sh_ld     = '0;
		cnt_ld    = CNT_W'(BW);
		rd_ld     = 1'b0;
		desel_ld  = 1'b0;
		reopen_ld = 1'b0;
		unique case (state_q)
			sfcs_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						sfcs_pkg::OP_INIT: begin
							go_clk   = ~sel_q;
							sh_ld    = {sfcs_pkg::CMD_WREN, sfcs_pkg::CMD_WRSR, status_q,
								{(SH_W-3*BW){1'b0}}};
							cnt_ld   = CNT_W'(3 * BW);
							desel_ld = 1'b1;
						end
						sfcs_pkg::OP_START_WRITE: begin
							go_clk    = ~sel_q;
							sh_ld     = {sfcs_pkg::CMD_WREN, sfcs_pkg::CMD_WRITE, addr_ext};
							desel_ld  = 1'b1;
							reopen_ld = 1'b1;
						end
						sfcs_pkg::OP_WRITE_BYTE: begin
							go_clk = sel_q;
							sh_ld  = {req.write_byte, {(SH_W-BW){1'b0}}};
						end
						sfcs_pkg::OP_START_READ: begin
							go_clk = ~sel_q;
							sh_ld  = {sfcs_pkg::CMD_READ, addr_ext, {BW{1'b0}}};
							cnt_ld = CNT_W'(FRAME2);
						end
						sfcs_pkg::OP_READ_BYTE: begin
							go_clk = sel_q;
							sh_ld  = {req.miso_bits, {(SH_W-BW){1'b0}}};
							rd_ld  = 1'b1;
						end
						sfcs_pkg::OP_END: begin
							go_desel = sel_q;
						end
						default: ;
					endcase
					if (go_clk) begin
						state_d = sfcs_pkg::ST_CLK;
					end else if (go_desel) begin
						state_d = sfcs_pkg::ST_DESEL;
					end
				end
			end
			sfcs_pkg::ST_CLK: begin
				if (emit && seg_done) begin
					state_d = desel_q ? sfcs_pkg::ST_DESEL : sfcs_pkg::ST_IDLE;
				end
			end
			sfcs_pkg::ST_DESEL: begin
				if (emit) begin
					state_d = reopen_q ? sfcs_pkg::ST_CLK : sfcs_pkg::ST_IDLE;
				end
			end
			default: state_d = sfcs_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= sfcs_pkg::STATUS_RESET;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= 1'b0;
			desel_q     <= 1'b0;
			reopen_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				status_q <= cfg.data;
			end
			if (emit && (state_q == sfcs_pkg::ST_CLK || state_q == sfcs_pkg::ST_DESEL)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (go_clk) begin
				sel_q    <= 1'b1;
				cnt_q    <= cnt_ld;
				rd_q     <= rd_ld;
				desel_q  <= desel_ld;
				reopen_q <= reopen_ld;
			end else if (go_desel) begin
				reopen_q <= 1'b0;
			end
			if (emit && state_q == sfcs_pkg::ST_CLK) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (emit && state_q == sfcs_pkg::ST_DESEL) begin
				if (reopen_q) begin
					// second frame of start write: WRITE plus address
					cnt_q    <= CNT_W'(FRAME2);
					desel_q  <= 1'b0;
					reopen_q <= 1'b0;
				end else begin
					sel_q <= 1'b0;
				end
			end
		end
	end

	// datapath: shift register and result fields
	always_ff @(posedge clk) begin
		if (go_clk) begin
			sh_q <= sh_ld;
		end
		if (emit && state_q == sfcs_pkg::ST_CLK) begin
			sh_q        <= {sh_q[SH_W-2:0], 1'b0};
			acc_q       <= {acc_q[BW-3:0], sh_q[SH_W-1]};
			cs_n_q      <= 1'b0;
			clk_pulse_q <= 1'b1;
			mosi_q      <= rd_q ? 1'b0 : sh_q[SH_W-1];
			rb_q        <= (rd_q && seg_done) ? {acc_q, sh_q[SH_W-1]} : '0;
			rv_q        <= rd_q & seg_done;
			last_q      <= final_clk;
		end
		if (emit && state_q == sfcs_pkg::ST_DESEL) begin
			cs_n_q      <= 1'b1;
			clk_pulse_q <= 1'b0;
			mosi_q      <= 1'b0;
			rb_q        <= '0;
			rv_q        <= 1'b0;
			last_q      <= ~reopen_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cs_n        = cs_n_q;
	assign rsp.clock_pulse = clk_pulse_q;
	assign rsp.mosi        = mosi_q;
	assign rsp.read_byte   = rb_q;
	assign rsp.read_valid  = rv_q;
	assign rsp.last        = last_q;

endmodule
